// ----- rtl/sync_frame_receiver_crc16_defines.svh -----
// Assertion macros for the sync frame receiver.
// Included by the top level; no other dependencies.
`ifndef SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sfrc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the sync frame receiver.
// No dependencies.
package sfrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hEA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h9B;

    // Configuration register indexes
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic prev_load;  // capture rx byte as previous byte
        logic start;      // seed CRC, clear body count
        logic body;       // store a payload byte or capture the CRC low byte
        logic rd_clear;   // restart payload readout
        logic rd_step;    // advance payload readout
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic sync_hit;   // previous and current byte form the start pattern
        logic body_last;  // current byte is the CRC high byte
        logic crc_ok;     // received CRC equals running CRC
        logic rd_last;    // readout index is at the last payload byte
    } stat_t;

    // CRC-16, polynomial 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/sfrc_ifs.sv -----
// Valid/ready channel interfaces for received bytes and payload results.
// Depends on nothing.
interface sfrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfrc_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last_flag;

    modport source (output valid, output payload_byte, output byte_index,
                    output last_flag, input ready);
    modport sink   (input valid, input payload_byte, input byte_index,
                    input last_flag, output ready);
endinterface

// ----- rtl/sfrc_datapath.sv -----
// Datapath: sync registers, previous byte, body counter, CRC, payload store, readout.
// Depends on sfrc_pkg.
module sfrc_datapath
    import sfrc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 64,
    parameter int FRAME_BYTES   = 68
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic [7:0] rx_byte,
    input  cmd_t       cmd,
    output stat_t      stat,
    output logic [7:0] payload_byte,
    output logic [5:0] byte_index,
    output logic       last_flag
);

    localparam int BODY_LEN = FRAME_BYTES - 2;
    localparam int EMIT_LEN = (FRAME_BYTES - 4 < PAYLOAD_BYTES) ? FRAME_BYTES - 4
                                                                : PAYLOAD_BYTES;
    localparam int ADDR_W   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CNT_W    = $clog2(FRAME_BYTES);

    logic [7:0]        sync_first_reg, sync_first_next;
    logic [7:0]        sync_second_reg, sync_second_next;
    logic [15:0]       sf_crc_reg, sf_crc_next;
    logic [7:0]        prev_reg, prev_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        crc_low_reg, crc_low_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]        rd_data_reg;
    logic [7:0]        store [PAYLOAD_BYTES];

    logic        store_we;
    logic        is_crc_low;
    logic [15:0] seed;
    logic [15:0] crc_upd;

    assign seed       = crc_byte(sf_crc_reg, sync_second_reg);
    assign crc_upd    = crc_byte(crc_reg, rx_byte);
    assign is_crc_low = (32'(count_reg) == BODY_LEN - 2);
    assign store_we   = cmd.body && !is_crc_low && (32'(count_reg) < PAYLOAD_BYTES);

    assign stat.sync_hit  = (rx_byte == sync_second_reg) && (prev_reg == sync_first_reg);
    assign stat.body_last = (32'(count_reg) >= BODY_LEN - 1);
    assign stat.crc_ok    = ({rx_byte, crc_low_reg} == crc_reg);
    assign stat.rd_last   = (32'(rd_idx_reg) == EMIT_LEN - 1);

    assign payload_byte = rd_data_reg;
    assign byte_index   = 6'(rd_idx_reg);
    assign last_flag    = stat.rd_last;

    always_comb
    begin
        sync_first_next  = sync_first_reg;
        sync_second_next = sync_second_reg;
        sf_crc_next      = sf_crc_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:
                begin
                    sync_first_next = cfg_data;
                    sf_crc_next     = crc_byte(CRC_INIT, cfg_data);
                end
                REG_SYNC_SECOND:
                begin
                    sync_second_next = cfg_data;
                end
                default:
                begin
                    sync_first_next = sync_first_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        prev_next    = cmd.prev_load ? rx_byte : prev_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        if (cmd.start)
        begin
            count_next = '0;
            crc_next   = seed;
        end
        else if (cmd.body)
        begin
            count_next = count_reg + CNT_W'(1);
            if (is_crc_low)
            begin
                crc_low_next = rx_byte;
            end
            else if (store_we)
            begin
                crc_next = crc_upd;
            end
        end
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_clear)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_step)
        begin
            rd_idx_next = rd_idx_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            sf_crc_reg      <= crc_byte(CRC_INIT, SYNC_FIRST_RST);
            prev_reg        <= 8'h00;
            count_reg       <= '0;
            crc_reg         <= CRC_INIT;
            crc_low_reg     <= 8'h00;
            rd_idx_reg      <= '0;
        end
        else
        begin
            sync_first_reg  <= sync_first_next;
            sync_second_reg <= sync_second_next;
            sf_crc_reg      <= sf_crc_next;
            prev_reg        <= prev_next;
            count_reg       <= count_next;
            crc_reg         <= crc_next;
            crc_low_reg     <= crc_low_next;
            rd_idx_reg      <= rd_idx_next;
        end
    end

    // Payload store: one write port from the body count, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store[count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        rd_data_reg <= store[rd_idx_reg];
    end

endmodule

// ----- rtl/sfrc_ctrl.sv -----
// Controller: hunt / body / readout state machine driving the datapath.
// Depends on sfrc_pkg.
module sfrc_ctrl
    import sfrc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  rx_valid,
    output logic  rx_ready,
    output logic  tx_valid,
    input  logic  tx_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [1:0] S_HUNT = 2'd0;
    localparam logic [1:0] S_BODY = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_SHOW = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       rx_xfer;
    logic       tx_xfer;

    assign rx_ready = (state_reg == S_HUNT) || (state_reg == S_BODY);
    assign tx_valid = (state_reg == S_SHOW);
    assign rx_xfer  = rx_valid && rx_ready;
    assign tx_xfer  = tx_valid && tx_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_HUNT:
            begin
                if (rx_xfer)
                begin
                    cmd.prev_load = 1'b1;
                    if (stat.sync_hit)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_BODY;
                    end
                end
            end
            S_BODY:
            begin
                if (rx_xfer)
                begin
                    if (stat.body_last)
                    begin
                        // CRC high byte: previous byte keeps the CRC low byte
                        if (stat.crc_ok)
                        begin
                            cmd.rd_clear = 1'b1;
                            state_next   = S_READ;
                        end
                        else
                        begin
                            state_next = S_HUNT;
                        end
                    end
                    else
                    begin
                        cmd.prev_load = 1'b1;
                        cmd.body      = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (tx_xfer)
                begin
                    if (stat.rd_last)
                    begin
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        cmd.rd_step = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/sync_frame_receiver_crc16.sv -----
// Top level of the sync frame receiver; depends on sfrc_pkg, sfrc_ifs,
// sfrc_ctrl, sfrc_datapath and the assertion macro header.
//
// rx carries received bytes, one per transfer. While hunting, a byte equal to
// sync_second right after one equal to sync_first opens a frame; the next
// FRAME_BYTES-2 bytes are the payload, the CRC low byte and the CRC high byte.
// CRC-16 (0x1021, seed 0xFFFF, MSB first) covers both sync bytes and the payload.
// A good frame is sent on tx as a burst of payload bytes with byte_index and
// last_flag on the final one; a bad frame is dropped without any output.
// rx takes one byte per cycle while hunting or inside a frame. After the CRC
// high byte of a good frame, rx holds ready low until the burst is done: the
// first payload byte and each next one pass through the S_READ state before tx
// is valid, set by the registered read port of the payload store.
// A stalled tx simply holds the current result. Reset returns to hunting with
// sync_first 0xEA and sync_second 0x9B; cfg_we writes register cfg_index.
`include "sync_frame_receiver_crc16_defines.svh"

module sync_frame_receiver_crc16
    import sfrc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 64,
    parameter int FRAME_BYTES   = 68
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    sfrc_rx_if.sink    rx,
    sfrc_tx_if.source  tx
);

    cmd_t  cmd;
    stat_t stat;

    sfrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .tx_valid (tx.valid),
        .tx_ready (tx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfrc_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .FRAME_BYTES   (FRAME_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (rx.rx_byte),
        .cmd          (cmd),
        .stat         (stat),
        .payload_byte (tx.payload_byte),
        .byte_index   (tx.byte_index),
        .last_flag    (tx.last_flag)
    );

    `SFRC_ASSERT_IMP(a_no_rx_during_burst, clk, rst_n, rx.ready, !tx.valid, "rx ready during payload burst")
    `SFRC_ASSERT_NXT(a_hunt_after_last, clk, rst_n, tx.valid && tx.ready && tx.last_flag, rx.ready, "no return to hunting after last byte")
    `SFRC_ASSERT_NXT(a_index_advance, clk, rst_n, tx.valid && tx.ready && !tx.last_flag, ##1 (tx.valid && tx.byte_index == $past(tx.byte_index, 2) + 6'd1), "payload index did not advance")

endmodule
